// File: sv/rwa_pkg.sv
`timescale 1ns / 1ps
// rwa_pkg: shared types and constants of the rollup window aggregate.
// Used by every module of the block; depends on nothing.
package rwa_pkg;

  localparam int unsigned VAL_W   = 64;  // Q32.32 value width
  localparam int unsigned TIME_W  = 32;  // timestamp width
  localparam int unsigned CNT_OUT_W = 9; // known_count field width
  localparam int unsigned XFF_W   = 17;  // unsigned Q1.16 threshold
  localparam int unsigned PPW_W   = 9;   // points_per_window register
  localparam int unsigned MODE_W  = 3;   // agg_mode register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Combiner codes; unused codes behave as sum
  localparam logic [MODE_W-1:0] AGG_AVG  = 3'd0;
  localparam logic [MODE_W-1:0] AGG_SUM  = 3'd1;
  localparam logic [MODE_W-1:0] AGG_LAST = 3'd2;
  localparam logic [MODE_W-1:0] AGG_MAX  = 3'd3;
  localparam logic [MODE_W-1:0] AGG_MIN  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XFF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PPW      = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0] AGG_MODE_RST = AGG_AVG;
  localparam logic [XFF_W-1:0]  XFF_RST      = 17'd0;
  localparam logic [TIME_W-1:0] STEP_RST     = 32'd60;
  localparam logic [PPW_W-1:0]  PPW_RST      = 9'd2;

  typedef struct packed {
    logic [TIME_W-1:0]       window_start;
    logic                    first_pt;
    logic [TIME_W-1:0]       pt_time;
    logic signed [VAL_W-1:0] point_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] agg_val;
    logic [CNT_OUT_W-1:0]    known_count;
    logic                    accepted;
    logic [TIME_W-1:0]       window_time;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic pt_load;    // take the input word into the window state
    logic div_start;  // launch the averaging division
    logic out_load;   // write the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic win_done;   // the word on the input closes its window
    logic need_div;   // closed window needs averaging
    logic div_done;   // divider finished
    logic out_free;   // output register can take a word this cycle
  } dp_status_t;

endpackage

// File: sv/rollup_window_aggregate.sv
`timescale 1ns / 1ps
// rollup_window_aggregate: one word per cycle while a window is open. After the
// point that closes a window the input stalls; the sequencer passes through its
// prepare and finish states, in average mode with known points also the serial
// divider, and the result is written once the sink frees the output register.
// Reset (rst_ni, async, active low) clears window state, the output valid and
// loads register defaults: average mode 0, threshold 0, step 60, 2 points.
module rollup_window_aggregate import rwa_pkg::*; #(
  parameter int unsigned MAX_WINDOW_POINTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  rwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  rwa_dp #(
    .MaxWindowPoints (MAX_WINDOW_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: sv/rwa_div.sv
`timescale 1ns / 1ps
// rwa_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on rwa_pkg for the value width.
module rwa_div import rwa_pkg::*; #(
  parameter int unsigned DivisorW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [VAL_W-1:0]    dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                done_o,
  output logic [VAL_W-1:0]    quot_o
);

  localparam int unsigned StepW = $clog2(VAL_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [VAL_W-1:0]    quot_q, quot_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;
  logic [DivisorW:0]   shifted;
  logic                fits;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign shifted = {rem_q, quot_q[VAL_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(VAL_W - 1);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[VAL_W-2:0], fits};
      rem_d  = fits ? DivisorW'(shifted - {1'b0, dvs_q}) : shifted[DivisorW-1:0];
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: sv/rwa_dp.sv
`timescale 1ns / 1ps
// rwa_dp: configuration registers, window state, combiner, divider and
// output register. Depends on rwa_pkg and rwa_div.
module rwa_dp import rwa_pkg::*; #(
  parameter int unsigned MaxWindowPoints = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_word_t              in_word_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_word_t             out_word_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  localparam int unsigned CntW  = $clog2(MaxWindowPoints + 1);
  localparam int unsigned ProdW = XFF_W + CntW;

  // Configuration
  logic [MODE_W-1:0] mode_q;
  logic [XFF_W-1:0]  xff_q;
  logic [TIME_W-1:0] step_q;
  logic [PPW_W-1:0]  ppw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= AGG_MODE_RST;
      xff_q  <= XFF_RST;
      step_q <= STEP_RST;
      ppw_q  <= PPW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AGG_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_XFF:      xff_q  <= cfg_wdata_i[XFF_W-1:0];
        CFG_STEP:     step_q <= cfg_wdata_i[TIME_W-1:0];
        CFG_PPW:      ppw_q  <= cfg_wdata_i[PPW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length: zero counts as one, clamped to the maximum
  logic [31:0]     ppw32, limit32;
  logic [CntW-1:0] limit;

  always_comb begin
    ppw32 = 32'(ppw_q);
    if (ppw32 == 32'd0) begin
      limit32 = 32'd1;
    end else if (ppw32 > 32'(MaxWindowPoints)) begin
      limit32 = 32'(MaxWindowPoints);
    end else begin
      limit32 = ppw32;
    end
  end
  assign limit = limit32[CntW-1:0];

  // Window state
  logic [TIME_W-1:0]       exp_q, exp_d;
  logic signed [VAL_W-1:0] acc_q, acc_d;
  logic [CntW-1:0]         tally_q, tally_d;
  logic [CntW-1:0]         pos_q, pos_d;
  logic [TIME_W-1:0]       win_q, win_d;

  logic                    open_win;
  logic [TIME_W-1:0]       base_exp;
  logic signed [VAL_W-1:0] acc_base, sum, sum_sat, val;
  logic [CntW-1:0]         tally_base, pos_next;
  logic                    hit, win_done;

  assign val = in_word_i.point_value;

  // Saturating add of the incoming value to the accumulator
  always_comb begin
    sum = acc_base + val;
    if (acc_base[VAL_W-1] == val[VAL_W-1] && sum[VAL_W-1] != val[VAL_W-1]) begin
      sum_sat = val[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sum_sat = sum;
    end
  end

  // Point update: open a window if needed, match slot time, combine
  always_comb begin
    open_win   = in_word_i.first_pt || (pos_q == '0);
    base_exp   = in_word_i.first_pt ? in_word_i.window_start : exp_q;
    win_d      = open_win ? base_exp : win_q;
    acc_base   = open_win ? '0 : acc_q;
    tally_base = open_win ? '0 : tally_q;
    hit        = in_word_i.pt_time == base_exp;
    acc_d      = acc_base;
    tally_d    = tally_base;
    if (hit) begin
      tally_d = tally_base + 1'b1;
      if (tally_base == '0) begin
        acc_d = val;
      end else begin
        case (mode_q)
          AGG_LAST: acc_d = val;
          AGG_MAX:  acc_d = (val > acc_base) ? val : acc_base;
          AGG_MIN:  acc_d = (val < acc_base) ? val : acc_base;
          default:  acc_d = sum_sat;
        endcase
      end
    end
    exp_d    = base_exp + step_q;
    pos_next = (open_win ? '0 : pos_q) + 1'b1;
    win_done = pos_next >= limit;
    pos_d    = win_done ? '0 : pos_next;
  end

  // A closed window keeps acc and tally for the result; the next point
  // clears them when it opens a new window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      acc_q   <= '0;
      tally_q <= '0;
      pos_q   <= '0;
      win_q   <= '0;
    end else if (cmd_i.pt_load) begin
      exp_q   <= exp_d;
      acc_q   <= acc_d;
      tally_q <= tally_d;
      pos_q   <= pos_d;
      win_q   <= win_d;
    end
  end

  // Averaging divides the magnitude, sign restored afterwards
  logic [VAL_W-1:0] acc_mag, quot;
  logic             div_done;

  assign acc_mag = acc_q[VAL_W-1] ? VAL_W'(-acc_q) : VAL_W'(acc_q);

  rwa_div #(
    .DivisorW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_mag),
    .divisor_i  (tally_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Result assembly
  logic signed [VAL_W-1:0] agg;
  logic [ProdW-1:0]        known_scaled, need_scaled;
  logic                    acc_ok;
  out_word_t               result;

  always_comb begin
    if (tally_q == '0) begin
      agg = '0;
    end else if (mode_q == AGG_AVG) begin
      agg = acc_q[VAL_W-1] ? signed'(-quot) : signed'(quot);
    end else begin
      agg = acc_q;
    end
    known_scaled       = ProdW'(tally_q) << 16;
    need_scaled        = ProdW'(xff_q) * ProdW'(limit);
    acc_ok             = known_scaled >= need_scaled;
    result.agg_val     = agg;
    result.known_count = CNT_OUT_W'(tally_q);
    result.accepted    = acc_ok;
    result.window_time = win_q;
  end

  // Output register
  logic      out_valid_q;
  out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign status_o.win_done = win_done;
  assign status_o.need_div = (mode_q == AGG_AVG) && (tally_q != '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// File: sv/rwa_ctrl.sv
`timescale 1ns / 1ps
// rwa_ctrl: sequencer that takes points, runs the closing division and
// hands the result to the output register. Depends on rwa_pkg.
module rwa_ctrl import rwa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,   // taking points
    ST_PREP,  // window closed, decide on division
    ST_DIV,   // division in progress
    ST_FIN    // waiting to write the result
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:  if (in_valid_i && status_i.win_done) state_d = ST_PREP;
      ST_PREP: state_d = status_i.need_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (status_i.div_done) state_d = ST_FIN;
      ST_FIN:  if (status_i.out_free) state_d = ST_RUN;
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from state
  assign in_stall_o      = state_q != ST_RUN;
  assign cmd_o.pt_load   = (state_q == ST_RUN) && in_valid_i;
  assign cmd_o.div_start = (state_q == ST_PREP) && status_i.need_div;
  assign cmd_o.out_load  = (state_q == ST_FIN) && status_i.out_free;

endmodule
